// ===== src/tpsc_pkg.sv =====
// Shared types and constants of the three-phase sine commutator.
// Holds the beat structs, register and opcode codes, and the sine ROM contents.
// No dependencies.
package tpsc_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 48;
	localparam int unsigned ROM_DEPTH = 48;
	localparam int unsigned ROM_AW = $clog2(ROM_DEPTH);

	localparam logic [7:0] PRESCALE_RESET = 8'd32;
	localparam logic [7:0] SPEED_PERIOD_RESET = 8'd16;
	localparam logic [7:0] GAIN_RESET = 8'd170;

	typedef enum logic [0:0] {
		OP_TICK = 1'b0,
		OP_SET_SPEED = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_PRESCALE_RELOAD = 2'd0,
		REG_SPEED_PERIOD = 2'd1,
		REG_AMPLITUDE_GAIN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		opcode_t opcode;
		logic signed [7:0] speed;
	} in_item_t;

	typedef struct packed {
		logic stepped;
		logic [7:0] duty_u;
		logic [7:0] duty_v;
		logic [7:0] duty_w;
	} out_item_t;

	// floor(127 + 127*sin(2*pi*k/48))
	localparam logic [7:0] SINE_ROM [ROM_DEPTH] = '{
		8'd127, 8'd143, 8'd159, 8'd175, 8'd190, 8'd204, 8'd216, 8'd227,
		8'd236, 8'd244, 8'd249, 8'd252, 8'd254, 8'd252, 8'd249, 8'd244,
		8'd236, 8'd227, 8'd216, 8'd204, 8'd190, 8'd175, 8'd159, 8'd143,
		8'd127, 8'd110, 8'd94, 8'd78, 8'd63, 8'd49, 8'd37, 8'd26,
		8'd17, 8'd9, 8'd4, 8'd1, 8'd0, 8'd1, 8'd4, 8'd9,
		8'd17, 8'd26, 8'd37, 8'd49, 8'd63, 8'd78, 8'd94, 8'd110
	};

endpackage

// ===== src/tpsc_duty.sv =====
// Duty lookup for one phase: phase index to ROM address, sine ROM, gain scaling.
// Depends on tpsc_pkg.
module tpsc_duty #(
	parameter int unsigned TABLE_DEPTH = tpsc_pkg::TABLE_DEPTH_DEF,
	localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
	input logic [IdxW-1:0] index,
	input logic [7:0] gain,
	output logic [7:0] duty
);

	localparam int unsigned MapDepth = 2 ** IdxW;

	logic [tpsc_pkg::ROM_AW-1:0] addr_map [MapDepth];
	logic [tpsc_pkg::ROM_AW-1:0] rom_addr;
	logic [15:0] product;

	// Index to ROM address is a constant table built at elaboration.
	for (genvar g = 0; g < MapDepth; g++) begin : g_map
		if (g < TABLE_DEPTH) begin : g_in
			localparam int unsigned Raw = (g * tpsc_pkg::ROM_DEPTH) / TABLE_DEPTH;
			assign addr_map[g] = tpsc_pkg::ROM_AW'(Raw);
		end else begin : g_out
			assign addr_map[g] = tpsc_pkg::ROM_AW'(tpsc_pkg::ROM_DEPTH - 1);
		end
	end

	always_comb begin
		rom_addr = addr_map[index];
		product = 16'(tpsc_pkg::SINE_ROM[rom_addr]) * 16'(gain);
		duty = product[15:8];
	end

endmodule

// ===== src/three_phase_sine_commutator_unit.sv =====
// Three-phase sine commutator: top level with channel handshakes, state and registers.
// Depends on tpsc_pkg and tpsc_duty.
//
// Usage:
// The in channel carries one beat per command: a PWM period tick or a set-speed
// command with a signed speed. Every input beat yields exactly one beat on the out
// channel: the stepped flag and the three held duties.
// The cfg channel writes prescale_reload (0), speed_period (1) and amplitude_gain (2);
// other indexes are ignored. cfg_ready is always high; write only while idle.
// An input beat passes through one input register; then the counter update,
// phase step, ROM read and gain multiply land in the output register.
// One beat per cycle is sustained while the receiver keeps out_ready high.
// When the receiver stalls, the result waits in the output register while the next
// beat is still taken into the input register; in_ready drops only when both are full.
// Reset puts the registers at their defaults (32, 16, 170), the prescaler at 32,
// the speed state at zero and backwards, the phases at 0, one third and two thirds
// of the table, and the held duties at zero.
module three_phase_sine_commutator_unit #(
	parameter int unsigned TABLE_DEPTH = tpsc_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tpsc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tpsc_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input tpsc_pkg::cfg_reg_t cfg_index,
	input logic [7:0] cfg_data
);

	localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
	localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_DEPTH - 1);
	localparam logic [IdxW-1:0] IdxThird = IdxW'(TABLE_DEPTH / 3);
	localparam logic [IdxW-1:0] IdxTwoThird = IdxW'((2 * TABLE_DEPTH) / 3);

	logic valid_s1;
	tpsc_pkg::in_item_t item_s1;
	logic out_valid_q;
	tpsc_pkg::out_item_t out_data_q;

	logic [7:0] prescale_reload_q;
	logic [7:0] speed_period_q;
	logic [7:0] gain_q;

	logic [7:0] prescale_count_q;
	logic [7:0] speed_count_q;
	logic [7:0] speed_mag_q;
	logic forward_q;
	logic [IdxW-1:0] idx_u_q, idx_v_q, idx_w_q;
	logic [7:0] held_u_q, held_v_q, held_w_q;

	logic advance;
	logic is_set;
	logic tick_due;
	logic step_en;
	logic [7:0] speed_bits;
	logic [7:0] set_mag;
	logic [7:0] speed_count_tick;
	logic [IdxW-1:0] idx_u_nx, idx_v_nx, idx_w_nx;
	logic [7:0] duty_u_nx, duty_v_nx, duty_w_nx;

	function automatic logic [IdxW-1:0] step_index(input logic [IdxW-1:0] idx,
			input logic fwd);
		logic [IdxW-1:0] res;
		if (fwd) begin
			res = (idx >= IdxLast) ? '0 : idx + IdxW'(1);
		end else begin
			res = (idx == '0 || 32'(idx) >= TABLE_DEPTH) ? IdxLast : idx - IdxW'(1);
		end
		return res;
	endfunction

	always_comb begin
		advance = valid_s1 && (!out_valid_q || out_ready);
		in_ready = !valid_s1 || advance;
		cfg_ready = 1'b1;
		is_set = item_s1.opcode == tpsc_pkg::OP_SET_SPEED;
		tick_due = !is_set && prescale_count_q == '0;
		speed_bits = item_s1.speed;
		// Two's complement magnitude; minus 128 gives 128.
		set_mag = speed_bits[7] ? (~speed_bits + 8'd1) : speed_bits;
		speed_count_tick = (speed_count_q == '0) ? speed_period_q : speed_count_q - 8'd1;
		step_en = tick_due && (speed_count_tick < speed_mag_q);
		idx_u_nx = step_index(idx_u_q, forward_q);
		idx_v_nx = step_index(idx_v_q, forward_q);
		idx_w_nx = step_index(idx_w_q, forward_q);
	end

	tpsc_duty #(.TABLE_DEPTH(TABLE_DEPTH)) u_duty_u (
		.index(idx_u_nx), .gain(gain_q), .duty(duty_u_nx)
	);
	tpsc_duty #(.TABLE_DEPTH(TABLE_DEPTH)) u_duty_v (
		.index(idx_v_nx), .gain(gain_q), .duty(duty_v_nx)
	);
	tpsc_duty #(.TABLE_DEPTH(TABLE_DEPTH)) u_duty_w (
		.index(idx_w_nx), .gain(gain_q), .duty(duty_w_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_reload_q <= tpsc_pkg::PRESCALE_RESET;
			speed_period_q <= tpsc_pkg::SPEED_PERIOD_RESET;
			gain_q <= tpsc_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpsc_pkg::REG_PRESCALE_RELOAD: prescale_reload_q <= cfg_data;
				tpsc_pkg::REG_SPEED_PERIOD: speed_period_q <= cfg_data;
				tpsc_pkg::REG_AMPLITUDE_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_count_q <= tpsc_pkg::PRESCALE_RESET;
			speed_count_q <= '0;
			speed_mag_q <= '0;
			forward_q <= 1'b0;
			idx_u_q <= '0;
			idx_v_q <= IdxThird;
			idx_w_q <= IdxTwoThird;
			held_u_q <= '0;
			held_v_q <= '0;
			held_w_q <= '0;
		end else if (advance) begin
			if (is_set) begin
				speed_count_q <= speed_period_q;
				speed_mag_q <= set_mag;
				forward_q <= !speed_bits[7];
			end else if (tick_due) begin
				prescale_count_q <= prescale_reload_q;
				speed_count_q <= speed_count_tick;
				if (step_en) begin
					idx_u_q <= idx_u_nx;
					idx_v_q <= idx_v_nx;
					idx_w_q <= idx_w_nx;
					held_u_q <= duty_u_nx;
					held_v_q <= duty_v_nx;
					held_w_q <= duty_w_nx;
				end
			end else begin
				prescale_count_q <= prescale_count_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.stepped <= step_en;
			out_data_q.duty_u <= step_en ? duty_u_nx : held_u_q;
			out_data_q.duty_v <= step_en ? duty_v_nx : held_v_q;
			out_data_q.duty_w <= step_en ? duty_w_nx : held_w_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// The phase spacing set at reset is kept by every step.
	assert property (@(posedge clk) disable iff (!arst_n)
		((idx_v_q >= idx_u_q) ? (32'(idx_v_q) - 32'(idx_u_q))
			: (32'(idx_v_q) + TABLE_DEPTH - 32'(idx_u_q))) == 32'(IdxThird))
		else $error("phase V drifted from phase U");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_u_q) < TABLE_DEPTH && 32'(idx_w_q) < TABLE_DEPTH)
		else $error("phase index left the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_set |=> !out_data_q.stepped)
		else $error("set-speed beat reported a step");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !step_en |=> $stable(held_u_q) && $stable(idx_u_q))
		else $error("phase state changed without a step");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while a stage was free");

endmodule
